### src/ctd_pkg.sv
`default_nettype none

package ctd_pkg;

    localparam int WORD_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int IN_DATA_W   = 4 * WORD_W;
    localparam int OUT_DATA_W  = 2 * WORD_W;
    localparam int CFG_INDEX_W = 3;

    // Square root: radicand is h << 16 padded to 48 bits, two bits per step
    localparam int RAD_W      = 48;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int REM_W      = ROOT_W + 2;
    localparam int CAND_W     = REM_W + 2;

    localparam int FLOW_W     = WORD_W + ROOT_W - FRAC_W;    // 40
    localparam int NET_W      = FLOW_W + 3;                  // 43, signed
    localparam int MAG_W      = NET_W - 1;                   // 42
    localparam int HI_W       = MAG_W - FRAC_W;              // 26
    localparam int HI_PROD_W  = HI_W + WORD_W;               // 58
    localparam int LO_PROD_W  = FRAC_W + WORD_W;             // 48
    localparam int SUM_W      = HI_PROD_W + 1;               // 59

    // Square-root lanes
    localparam int LANES     = 3;
    localparam int LANE_OUT1 = 0;
    localparam int LANE_OUT2 = 1;
    localparam int LANE_CPL  = 2;

    // Input register + root steps + multiply, net, magnitude, scale, sum, output
    localparam int PIPE_LATENCY = SQRT_STEPS + 7;
    localparam int COUNT_W      = 6;

    localparam logic [WORD_W-1:0] RST_OUTLET_GAIN  = 32'd1742;
    localparam logic [WORD_W-1:0] RST_COUPLING_GAIN = 32'd871;
    localparam logic [WORD_W-1:0] RST_INV_AREA     = 32'd65536;

    localparam logic [SUM_W-1:0] POS_LIMIT = SUM_W'(64'h0000_0000_7FFF_FFFF);
    localparam logic [SUM_W-1:0] NEG_LIMIT = SUM_W'(64'h0000_0000_8000_0000);
    localparam logic [WORD_W-1:0] POS_SAT  = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] NEG_SAT  = 32'h8000_0000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_OUTLET_GAIN_ONE  = 3'd0,
        CFG_OUTLET_GAIN_TWO  = 3'd1,
        CFG_COUPLING_GAIN    = 3'd2,
        CFG_INVERSE_AREA_ONE = 3'd3,
        CFG_INVERSE_AREA_TWO = 3'd4
    } cfg_reg_t;

    // Fields that ride alongside the square-root lanes
    typedef struct packed {
        logic signed [WORD_W-1:0] inflow_one;
        logic signed [WORD_W-1:0] inflow_two;
        logic                     one_higher;
    } side_t;

endpackage

`default_nettype wire

### src/coupled_two_tank_derivative.sv
// Coupled two-tank level derivative, fully pipelined.
//
// Input words arrive on the s_axis channel: two tank levels and two pumped
// inflows, signed Q16.16. Each accepted word yields exactly one output word
// on m_axis: the level derivatives of both tanks, signed Q16.16, saturated.
// Gains and reciprocal areas are loaded through the cfg write channel
// (index 0..4); cfg_ready is always high and writes to other indices drop.
// Write the registers only while the pipeline is empty.
//
// The pipeline is one input register, 24 square-root steps (one result bit
// per stage, three roots in parallel), then multiply, net flow, magnitude,
// area scaling, sum and output registers. Throughput is one word per cycle
// while m_axis is not stalled; the 24-stage root pipeline sets the depth.
//
// When the receiver stalls, the output register holds its word and the
// pipeline keeps filling until its last stage is occupied, then s_axis_tready
// drops; nothing is lost or repeated. Reset empties the pipeline and restores
// the register defaults.
`default_nettype none

module coupled_two_tank_derivative
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // cfg write channel
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [ctd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [ctd_pkg::WORD_W-1:0]           cfg_data,
    // input words
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // level_tank_one, level_tank_two, inflow_tank_one, inflow_tank_two
    input  wire logic [ctd_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // output words
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // rate_tank_one, rate_tank_two
    output logic [ctd_pkg::OUT_DATA_W-1:0]            m_axis_tdata
);

    localparam int W  = ctd_pkg::WORD_W;
    localparam int NS = ctd_pkg::SQRT_STEPS;
    localparam int NL = ctd_pkg::LANES;

    // Configuration registers
    logic [W-1:0] outlet_gain_one_reg;
    logic [W-1:0] outlet_gain_two_reg;
    logic [W-1:0] coupling_gain_reg;
    logic [W-1:0] inverse_area_one_reg;
    logic [W-1:0] inverse_area_two_reg;

    // Square-root pipeline; index 0 is the input register
    logic [ctd_pkg::RAD_W-1:0]  sq_rad_reg  [0:NS][0:NL-1];
    logic [ctd_pkg::RAD_W-1:0]  sq_rad_next [0:NS][0:NL-1];
    logic [ctd_pkg::REM_W-1:0]  sq_rem_reg  [0:NS][0:NL-1];
    logic [ctd_pkg::REM_W-1:0]  sq_rem_next [0:NS][0:NL-1];
    logic [ctd_pkg::ROOT_W-1:0] sq_root_reg [0:NS][0:NL-1];
    logic [ctd_pkg::ROOT_W-1:0] sq_root_next[0:NS][0:NL-1];
    ctd_pkg::side_t             sq_side_reg [0:NS];
    ctd_pkg::side_t             sq_side_next[0:NS];
    logic                       sq_v_reg    [0:NS];

    // Flow products
    logic [ctd_pkg::FLOW_W-1:0] flow_reg [0:NL-1];
    logic [ctd_pkg::FLOW_W-1:0] flow_next[0:NL-1];
    ctd_pkg::side_t             mul_side_reg;
    logic                       mul_v_reg;

    // Net flows
    logic signed [ctd_pkg::NET_W-1:0] net_reg [0:1];
    logic signed [ctd_pkg::NET_W-1:0] net_next[0:1];
    logic                             net_v_reg;

    // Magnitudes
    logic [ctd_pkg::MAG_W-1:0] mag_reg [0:1];
    logic [ctd_pkg::MAG_W-1:0] mag_next[0:1];
    logic                      mag_neg_reg[0:1];
    logic                      mag_v_reg;

    // Area scaling partial products
    logic [ctd_pkg::HI_PROD_W-1:0] hi_prod_reg [0:1];
    logic [ctd_pkg::HI_PROD_W-1:0] hi_prod_next[0:1];
    logic [W-1:0]                  lo_part_reg [0:1];
    logic [W-1:0]                  lo_part_next[0:1];
    logic                          scl_neg_reg [0:1];
    logic                          scl_v_reg;

    // Summed magnitudes
    logic [ctd_pkg::SUM_W-1:0] sum_reg [0:1];
    logic                      sum_neg_reg[0:1];
    logic                      sum_v_reg;

    // Output register
    logic [W-1:0] rate_reg [0:1];
    logic [W-1:0] rate_next[0:1];
    logic         out_v_reg;

    logic         adv;
    logic         out_load;
    logic [W-1:0] lane_gain[0:NL-1];
    logic [W-1:0] lane_inv [0:1];

    // Advance whenever the last stage is empty or the output register frees up
    assign out_load      = !out_v_reg || m_axis_tready;
    assign adv           = !sum_v_reg || out_load;
    assign s_axis_tready = adv;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {rate_reg[1], rate_reg[0]};

    assign lane_gain[ctd_pkg::LANE_OUT1] = outlet_gain_one_reg;
    assign lane_gain[ctd_pkg::LANE_OUT2] = outlet_gain_two_reg;
    assign lane_gain[ctd_pkg::LANE_CPL]  = coupling_gain_reg;
    assign lane_inv[0] = inverse_area_one_reg;
    assign lane_inv[1] = inverse_area_two_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outlet_gain_one_reg  <= ctd_pkg::RST_OUTLET_GAIN;
            outlet_gain_two_reg  <= ctd_pkg::RST_OUTLET_GAIN;
            coupling_gain_reg    <= ctd_pkg::RST_COUPLING_GAIN;
            inverse_area_one_reg <= ctd_pkg::RST_INV_AREA;
            inverse_area_two_reg <= ctd_pkg::RST_INV_AREA;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (ctd_pkg::cfg_reg_t'(cfg_index))
                ctd_pkg::CFG_OUTLET_GAIN_ONE:  outlet_gain_one_reg  <= cfg_data;
                ctd_pkg::CFG_OUTLET_GAIN_TWO:  outlet_gain_two_reg  <= cfg_data;
                ctd_pkg::CFG_COUPLING_GAIN:    coupling_gain_reg    <= cfg_data;
                ctd_pkg::CFG_INVERSE_AREA_ONE: inverse_area_one_reg <= cfg_data;
                ctd_pkg::CFG_INVERSE_AREA_TWO: inverse_area_two_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input stage: clamp levels, form the level difference and its sign.
    // Then one root bit per stage: bring down two radicand bits, try root*4+1
    always_comb
    begin
        logic [W-2:0] h1;
        logic [W-2:0] h2;
        logic [W-2:0] dh;
        logic         gt;
        logic [ctd_pkg::CAND_W-1:0] cand;
        logic [ctd_pkg::CAND_W-1:0] trial;

        h1 = s_axis_tdata[W-1]   ? '0 : s_axis_tdata[W-2:0];
        h2 = s_axis_tdata[2*W-1] ? '0 : s_axis_tdata[2*W-2:W];
        gt = h1 > h2;
        dh = gt ? (h1 - h2) : (h2 - h1);
        sq_rad_next[0][ctd_pkg::LANE_OUT1] = {1'b0, h1, 16'd0};
        sq_rad_next[0][ctd_pkg::LANE_OUT2] = {1'b0, h2, 16'd0};
        sq_rad_next[0][ctd_pkg::LANE_CPL]  = {1'b0, dh, 16'd0};
        for (int l = 0; l < NL; l++)
        begin
            sq_rem_next[0][l]  = '0;
            sq_root_next[0][l] = '0;
        end
        sq_side_next[0].inflow_one = s_axis_tdata[3*W-1:2*W];
        sq_side_next[0].inflow_two = s_axis_tdata[4*W-1:3*W];
        sq_side_next[0].one_higher = gt;

        for (int k = 1; k <= NS; k++)
        begin
            sq_side_next[k] = sq_side_reg[k-1];
            for (int l = 0; l < NL; l++)
            begin
                cand  = {sq_rem_reg[k-1][l], sq_rad_reg[k-1][l][ctd_pkg::RAD_W-1 -: 2]};
                trial = {2'b00, sq_root_reg[k-1][l], 2'b01};
                sq_rad_next[k][l] = {sq_rad_reg[k-1][l][ctd_pkg::RAD_W-3:0], 2'b00};
                if (cand >= trial)
                begin
                    sq_rem_next[k][l]  = ctd_pkg::REM_W'(cand - trial);
                    sq_root_next[k][l] = {sq_root_reg[k-1][l][ctd_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    sq_rem_next[k][l]  = ctd_pkg::REM_W'(cand);
                    sq_root_next[k][l] = {sq_root_reg[k-1][l][ctd_pkg::ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    // Back end: flow products, net flows, magnitudes, scaling, saturation
    always_comb
    begin
        logic [W+ctd_pkg::ROOT_W-1:0]     prod;
        logic signed [ctd_pkg::NET_W-1:0] in1;
        logic signed [ctd_pkg::NET_W-1:0] in2;
        logic signed [ctd_pkg::NET_W-1:0] f1;
        logic signed [ctd_pkg::NET_W-1:0] f2;
        logic signed [ctd_pkg::NET_W-1:0] fc;
        logic signed [ctd_pkg::NET_W-1:0] absn;
        logic [ctd_pkg::LO_PROD_W-1:0]    lo_prod;

        for (int l = 0; l < NL; l++)
        begin
            prod = {{ctd_pkg::ROOT_W{1'b0}}, lane_gain[l]}
                 * {{W{1'b0}}, sq_root_reg[NS][l]};
            flow_next[l] = prod[W+ctd_pkg::ROOT_W-1:ctd_pkg::FRAC_W];
        end

        in1 = ctd_pkg::NET_W'(mul_side_reg.inflow_one);
        in2 = ctd_pkg::NET_W'(mul_side_reg.inflow_two);
        f1  = $signed({3'b000, flow_reg[ctd_pkg::LANE_OUT1]});
        f2  = $signed({3'b000, flow_reg[ctd_pkg::LANE_OUT2]});
        fc  = $signed({3'b000, flow_reg[ctd_pkg::LANE_CPL]});
        // Coupling runs from the higher tank to the lower
        if (mul_side_reg.one_higher)
        begin
            net_next[0] = in1 - f1 - fc;
            net_next[1] = in2 - f2 + fc;
        end
        else
        begin
            net_next[0] = in1 - f1 + fc;
            net_next[1] = in2 - f2 - fc;
        end

        for (int t = 0; t < 2; t++)
        begin
            absn = net_reg[t][ctd_pkg::NET_W-1] ? -net_reg[t] : net_reg[t];
            mag_next[t] = absn[ctd_pkg::MAG_W-1:0];

            hi_prod_next[t] = {{W{1'b0}}, mag_reg[t][ctd_pkg::MAG_W-1:ctd_pkg::FRAC_W]}
                            * {{ctd_pkg::HI_W{1'b0}}, lane_inv[t]};
            lo_prod = {{W{1'b0}}, mag_reg[t][ctd_pkg::FRAC_W-1:0]}
                    * {{ctd_pkg::FRAC_W{1'b0}}, lane_inv[t]};
            lo_part_next[t] = lo_prod[ctd_pkg::LO_PROD_W-1:ctd_pkg::FRAC_W];

            if (sum_neg_reg[t])
                rate_next[t] = (sum_reg[t] > ctd_pkg::NEG_LIMIT) ? ctd_pkg::NEG_SAT
                             : (32'd0 - sum_reg[t][W-1:0]);
            else
                rate_next[t] = (sum_reg[t] > ctd_pkg::POS_LIMIT) ? ctd_pkg::POS_SAT
                             : sum_reg[t][W-1:0];
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NS; k++)
                sq_v_reg[k] <= 1'b0;
            mul_v_reg <= 1'b0;
            net_v_reg <= 1'b0;
            mag_v_reg <= 1'b0;
            scl_v_reg <= 1'b0;
            sum_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                sq_v_reg[0] <= s_axis_tvalid;
                for (int k = 1; k <= NS; k++)
                    sq_v_reg[k] <= sq_v_reg[k-1];
                mul_v_reg <= sq_v_reg[NS];
                net_v_reg <= mul_v_reg;
                mag_v_reg <= net_v_reg;
                scl_v_reg <= mag_v_reg;
                sum_v_reg <= scl_v_reg;
            end
            if (out_load)
                out_v_reg <= sum_v_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k <= NS; k++)
            begin
                sq_side_reg[k] <= sq_side_next[k];
                for (int l = 0; l < NL; l++)
                begin
                    sq_rad_reg[k][l]  <= sq_rad_next[k][l];
                    sq_rem_reg[k][l]  <= sq_rem_next[k][l];
                    sq_root_reg[k][l] <= sq_root_next[k][l];
                end
            end
            for (int l = 0; l < NL; l++)
                flow_reg[l] <= flow_next[l];
            mul_side_reg <= sq_side_reg[NS];
            for (int t = 0; t < 2; t++)
            begin
                net_reg[t]     <= net_next[t];
                mag_reg[t]     <= mag_next[t];
                mag_neg_reg[t] <= net_reg[t][ctd_pkg::NET_W-1];
                hi_prod_reg[t] <= hi_prod_next[t];
                lo_part_reg[t] <= lo_part_next[t];
                scl_neg_reg[t] <= mag_neg_reg[t];
                sum_reg[t]     <= {1'b0, hi_prod_reg[t]}
                                + {{(ctd_pkg::SUM_W-W){1'b0}}, lo_part_reg[t]};
                sum_neg_reg[t] <= scl_neg_reg[t];
            end
        end
        if (out_load)
        begin
            rate_reg[0] <= rate_next[0];
            rate_reg[1] <= rate_next[1];
        end
    end

endmodule

`default_nettype wire

### src/ctd_checker.sv
`default_nettype none

module ctd_checker
(
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [ctd_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    logic [ctd_pkg::COUNT_W-1:0] count_reg;
    logic [ctd_pkg::COUNT_W-1:0] count_next;
    logic                        acc_in;
    logic                        acc_out;

    assign acc_in  = s_axis_tvalid && s_axis_tready;
    assign acc_out = m_axis_tvalid && m_axis_tready;

    // Words accepted but not yet delivered
    always_comb
    begin
        count_next = count_reg;
        if (acc_in && !acc_out)
            count_next = count_reg + 1'b1;
        else if (acc_out && !acc_in)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // Input back-pressure only comes from a stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output back-pressure");

    // No output word without an accepted input word
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> count_reg != '0)
        else $error("output word with nothing in flight");

    // In-flight words never exceed the pipeline depth
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ctd_pkg::COUNT_W'(ctd_pkg::PIPE_LATENCY))
        else $error("more words in flight than pipeline stages");

endmodule

bind coupled_two_tank_derivative ctd_checker u_ctd_checker (.*);

`default_nettype wire
